/* hdl/lpiir_pkg.sv */
// ---------------------------------------------------------------------------
// lpiir_pkg: shared constants and types of the low-pass biquad
// Coefficient format, register indexes and the control/status bundles
// that pass between the sequencer and the serial multiply-accumulate unit.
// ---------------------------------------------------------------------------
package lpiir_pkg;

    // default sample width and extra history fraction bits
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int GUARD_BITS_DEF   = 8;

    // coefficients are signed Q7.24
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 24;

    // register file: four 32-bit words at byte addresses 0, 4, 8, 12
    localparam int APB_AW  = 4;
    localparam int REG_IW  = 2;
    localparam logic [REG_IW-1:0] REG_K0 = 2'd0;
    localparam logic [REG_IW-1:0] REG_K1 = 2'd1;
    localparam logic [REG_IW-1:0] REG_K2 = 2'd2;
    localparam logic [REG_IW-1:0] REG_K3 = 2'd3;

    // command into the serial MAC
    typedef struct packed {
        logic start;   // load operands and begin a product
        logic clear;   // zero the accumulator at start
    } t_mac_ctl;

    // status out of the serial MAC
    typedef struct packed {
        logic busy;    // product in progress
        logic done;    // one-cycle pulse, accumulator holds the new sum
    } t_mac_sts;

endpackage

/* hdl/lpiir_mac.sv */
// ---------------------------------------------------------------------------
// lpiir_mac: bit-serial signed multiply-accumulate
// Multiplier bits enter LSB first, one per cycle; the multiplicand shifts
// left. The last multiplier bit used (its sign) is subtracted.
// ---------------------------------------------------------------------------
module lpiir_mac #(
    parameter int ACC_W = 64,
    parameter int OP_W  = 32,
    parameter int LEN_W = $clog2(OP_W + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpiir_pkg::t_mac_ctl    i_ctl,
    input  logic [LEN_W-1:0]       i_len,     // multiplier bits to use, >= 1
    input  logic [ACC_W-1:0]       i_mcand,   // sign-extended multiplicand
    input  logic [OP_W-1:0]        i_mplier,  // two's complement multiplier
    output lpiir_pkg::t_mac_sts    o_sts,
    output logic [ACC_W-1:0]       o_acc
);

    logic             r_busy;
    logic             r_done;
    logic [LEN_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_mcand;
    logic [OP_W-1:0]  r_mplier;
    logic [ACC_W-1:0] r_acc;

    logic [ACC_W-1:0] term;
    logic             last;
    logic [ACC_W-1:0] n_acc;

    assign term  = r_mplier[0] ? r_mcand : '0;
    assign last  = (r_cnt == LEN_W'(1));
    // sign bit carries weight -2^(n-1)
    assign n_acc = last ? (r_acc - term) : (r_acc + term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_cnt    <= i_len;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_mcand  <= {r_mcand[ACC_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[OP_W-1:1]};
            r_cnt    <= r_cnt - LEN_W'(1);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;

endmodule

/* hdl/second_order_lowpass_iir.sv */
// ---------------------------------------------------------------------------
// second_order_lowpass_iir: bilinear-transform low-pass biquad
// S = SAMPLE_WIDTH and G = GUARD_FRACTION_BITS below.
// One sample at a time: the input closes until the result of the last one
//   is in the output register; all four products go through one bit-serial
//   MAC, one multiplier bit per cycle.
// Reset: synchronous, active low; clears coefficients, history, FSM, valid.
// ---------------------------------------------------------------------------
//
// y = k0 * (k1*y1 + k2*y2 + k3*(x + 2*x1 + x2))
//
// Product schedule on the shared MAC:
//   pass 0  k1 * y1          (accumulator cleared)
//   pass 1  k2 * y2
//   pass 2  (k3 << G) * xs   xs = x + 2*x1 + x2
//   round   inner = sat(round(acc >> 24), S+G+8)
//   pass 3  k0 * inner       (accumulator cleared)
//   round   wide  = round(acc >> 24)
//   finish  y = sat(round(wide >> G), S), history y1 = sat(wide, S+G)
// The clip flag is the OR of all three saturations.
//
// Output sits in a register so the next input beat can be taken while the
// result waits on m_tready.
module second_order_lowpass_iir #(
    parameter int SAMPLE_WIDTH        = lpiir_pkg::SAMPLE_WIDTH_DEF,
    parameter int GUARD_FRACTION_BITS = lpiir_pkg::GUARD_BITS_DEF,
    parameter int DATA_W              = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // input sample stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [DATA_W-1:0]            s_tdata,   // [S-1:0] sample_in

    // filtered sample stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [DATA_W-1:0]            m_tdata,   // [S-1:0] filtered_out
    output logic                         m_tuser,   // [0] clipped

    // coefficient registers
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpiir_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int S       = SAMPLE_WIDTH;
    localparam int G       = GUARD_FRACTION_BITS;
    localparam int CW      = lpiir_pkg::COEF_W;
    localparam int CF      = lpiir_pkg::COEF_FRAC;
    localparam int HIST_W  = S + G;
    localparam int INNER_W = S + G + 8;
    localparam int XS_W    = S + 2;
    localparam int OP_W    = INNER_W;
    localparam int ACC_W   = CW + INNER_W;
    localparam int WIDE_W  = ACC_W - CF;
    localparam int YR_W    = WIDE_W - G;
    localparam int LEN_W   = $clog2(OP_W + 1);

    localparam logic [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (CF - 1);
    localparam logic [WIDE_W-1:0] G_HALF   = (WIDE_W'(1) << G) >> 1;

    // one-hot sequencer
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PY1  = 8'b0000_0010,  // k1*y1 running
        ST_PY2  = 8'b0000_0100,  // k2*y2 running
        ST_PX   = 8'b0000_1000,  // k3*xs running
        ST_RND1 = 8'b0001_0000,  // round/saturate inner sum, start k0 pass
        ST_PK0  = 8'b0010_0000,  // k0*inner running
        ST_RND2 = 8'b0100_0000,  // round product to history precision
        ST_FIN  = 8'b1000_0000   // output and history update
    } t_state;

    t_state r_state, n_state;

    // coefficients
    logic [CW-1:0] r_k0, r_k1, r_k2, r_k3;

    // history
    logic [S-1:0]      r_x1, r_x2;
    logic [HIST_W-1:0] r_y1, r_y2;

    // per-sample working registers
    logic [S-1:0]      r_x;
    logic              r_clip;
    logic [WIDE_W-1:0] r_wide;

    // output register
    logic              r_out_valid;
    logic [S-1:0]      r_out_y;
    logic              r_out_clip;

    // MAC hookup
    lpiir_pkg::t_mac_ctl mac_ctl;
    lpiir_pkg::t_mac_sts mac_sts;
    logic [LEN_W-1:0]    mac_len;
    logic [ACC_W-1:0]    mac_mcand;
    logic [OP_W-1:0]     mac_mplier;
    logic [ACC_W-1:0]    mac_acc;
    logic                mac_fin;

    // datapath helpers
    localparam int REG_IDX_W = lpiir_pkg::REG_IW;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 in_acc;
    logic                 out_free;
    logic [XS_W-1:0]      xs;
    logic [ACC_W-1:0]     acc_rnd;
    logic [WIDE_W-1:0]    acc_hi;
    logic [WIDE_W-INNER_W:0] inner_top;
    logic                 inner_ovf;
    logic [INNER_W-1:0]   inner_sat;
    logic [WIDE_W-HIST_W:0] hist_top;
    logic                 hist_ovf;
    logic [HIST_W-1:0]    hist_sat;
    logic [WIDE_W-1:0]    wide_rnd;
    logic [YR_W-1:0]      y_full;
    logic [YR_W-S:0]      y_top;
    logic                 y_ovf;
    logic [S-1:0]         y_sat;

    // ---------------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------------
    assign reg_idx = paddr[lpiir_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0 <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                lpiir_pkg::REG_K0: r_k0 <= pwdata;
                lpiir_pkg::REG_K1: r_k1 <= pwdata;
                lpiir_pkg::REG_K2: r_k2 <= pwdata;
                lpiir_pkg::REG_K3: r_k3 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lpiir_pkg::REG_K0: prdata = r_k0;
            lpiir_pkg::REG_K1: prdata = r_k1;
            lpiir_pkg::REG_K2: prdata = r_k2;
            lpiir_pkg::REG_K3: prdata = r_k3;
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------------
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;
    assign mac_fin  = mac_sts.done && !mac_sts.busy;

    // weighted input sum, S+2 bits is enough for x + 2*x1 + x2
    assign xs = {{2{r_x[S-1]}}, r_x}
              + {r_x1[S-1], r_x1, 1'b0}
              + {{2{r_x2[S-1]}}, r_x2};

    // round half up at the coefficient point
    assign acc_rnd = mac_acc + ACC_HALF;
    assign acc_hi  = acc_rnd[ACC_W-1:CF];

    // inner sum saturation
    assign inner_top = acc_hi[WIDE_W-1:INNER_W-1];
    assign inner_ovf = !((&inner_top) || !(|inner_top));
    assign inner_sat = inner_ovf ? {acc_hi[WIDE_W-1], {(INNER_W-1){~acc_hi[WIDE_W-1]}}}
                                 : acc_hi[INNER_W-1:0];

    // history saturation
    assign hist_top = r_wide[WIDE_W-1:HIST_W-1];
    assign hist_ovf = !((&hist_top) || !(|hist_top));
    assign hist_sat = hist_ovf ? {r_wide[WIDE_W-1], {(HIST_W-1){~r_wide[WIDE_W-1]}}}
                               : r_wide[HIST_W-1:0];

    // output rounding to integer and saturation
    assign wide_rnd = r_wide + G_HALF;
    assign y_full   = wide_rnd[WIDE_W-1:G];
    assign y_top    = y_full[YR_W-1:S-1];
    assign y_ovf    = !((&y_top) || !(|y_top));
    assign y_sat    = y_ovf ? {y_full[YR_W-1], {(S-1){~y_full[YR_W-1]}}}
                            : y_full[S-1:0];

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    assign s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        mac_ctl     = '0;
        mac_len     = LEN_W'(HIST_W);
        mac_mcand   = {{(ACC_W-CW){r_k1[CW-1]}}, r_k1};
        mac_mplier  = {{(OP_W-HIST_W){r_y1[HIST_W-1]}}, r_y1};
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    mac_ctl.start = 1'b1;
                    mac_ctl.clear = 1'b1;
                    n_state       = ST_PY1;
                end
            end
            ST_PY1: begin
                mac_mcand  = {{(ACC_W-CW){r_k2[CW-1]}}, r_k2};
                mac_mplier = {{(OP_W-HIST_W){r_y2[HIST_W-1]}}, r_y2};
                if (mac_fin) begin
                    mac_ctl.start = 1'b1;
                    n_state       = ST_PY2;
                end
            end
            ST_PY2: begin
                mac_len    = LEN_W'(XS_W);
                mac_mcand  = {{(ACC_W-CW){r_k3[CW-1]}}, r_k3} << G;
                mac_mplier = {{(OP_W-XS_W){xs[XS_W-1]}}, xs};
                if (mac_fin) begin
                    mac_ctl.start = 1'b1;
                    n_state       = ST_PX;
                end
            end
            ST_PX: begin
                if (mac_fin) begin
                    n_state = ST_RND1;
                end
            end
            ST_RND1: begin
                mac_len       = LEN_W'(INNER_W);
                mac_mcand     = {{(ACC_W-CW){r_k0[CW-1]}}, r_k0};
                mac_mplier    = inner_sat;
                mac_ctl.start = 1'b1;
                mac_ctl.clear = 1'b1;
                n_state       = ST_PK0;
            end
            ST_PK0: begin
                if (mac_fin) begin
                    n_state = ST_RND2;
                end
            end
            ST_RND2: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_x2        <= r_x1;
                r_x1        <= r_x;
                r_y2        <= r_y1;
                r_y1        <= hist_sat;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= s_tdata[S-1:0];
        end
        if (r_state == ST_RND1) begin
            r_clip <= inner_ovf;
        end
        if (r_state == ST_RND2) begin
            r_wide <= acc_hi;
        end
        if (r_state == ST_FIN && out_free) begin
            r_out_y    <= y_sat;
            r_out_clip <= r_clip || y_ovf || hist_ovf;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = DATA_W'(r_out_y);
    assign m_tuser  = r_out_clip;

    // ---------------------------------------------------------------------
    // shared serial MAC
    // ---------------------------------------------------------------------
    lpiir_mac #(
        .ACC_W (ACC_W),
        .OP_W  (OP_W),
        .LEN_W (LEN_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_len    (mac_len),
        .i_mcand  (mac_mcand),
        .i_mplier (mac_mplier),
        .o_sts    (mac_sts),
        .o_acc    (mac_acc)
    );

endmodule

/* hdl/lpiir_chk.sv */
// ---------------------------------------------------------------------------
// lpiir_chk: port-level checks for the low-pass biquad
// Tracks samples in flight from the stream handshakes.
// ---------------------------------------------------------------------------
module lpiir_chk #(
    parameter int DATA_W = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tuser
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] r_pend;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    // one sample in work plus one parked in the output register at most
    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two samples in flight");

    // no result without a sample behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> r_pend != 2'd0)
        else $error("output beat with no input outstanding");

    // one sample at a time: input closes right after a beat
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !s_tready)
        else $error("input taken while previous sample in work");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

endmodule

bind second_order_lowpass_iir lpiir_chk #(
    .DATA_W (DATA_W)
) u_lpiir_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the second-order low-pass biquad
// Streams samples through the filter under random source bursts and sink
// stalls. A bit-exact predictor tracks coefficients and history and checks
// every output beat in order. Coefficients are loaded over APB between runs
// and read back.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int SAMP_W  = lpiir_pkg::SAMPLE_WIDTH_DEF;
    localparam int GUARD_W = lpiir_pkg::GUARD_BITS_DEF;
    localparam int HIST_W  = SAMP_W + GUARD_W;
    localparam int INNER_W = SAMP_W + GUARD_W + 8;
    localparam int ONE_Q24 = 1 << lpiir_pkg::COEF_FRAC;
    localparam int ITEMS_PER_RUN = 60;
    localparam int RUNS          = 10;
    localparam int DRAIN_CYCLES  = 120;   // idle margin before the final check

    typedef struct packed {
        logic [SAMP_W-1:0] sample;
        logic              clipped;
    } t_filt_beat;

    // sink ready patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} t_rx_mode;
    // coefficient sets used by the random runs
    typedef enum int {CF_LOWPASS, CF_WILD, CF_RAMP, CF_MODERATE, CF_EDGE_GAIN} t_coef_kind;
    // sample flavors
    typedef enum int {SM_FULL, SM_SMALL, SM_EXTREME, SM_HOLD} t_samp_kind;

    // ---------------------------------------------------------------- DUT io
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [15:0] sample_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] filtered_out
    logic        m_tuser;           // [0] clipped
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [lpiir_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    second_order_lowpass_iir dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------- bench state
    logic [15:0]  sample_q[$];      // samples waiting to be sent
    t_filt_beat   filtered_q[$];    // predicted output beats, oldest first
    logic [31:0]  coef_reg [4];     // mirror of the coefficient registers
    longint       hist_x1, hist_x2, hist_y1, hist_y2;
    int           err_count = 0;
    int           gap_left = 0, burst_left = 0;
    int           rdy_left = 0;
    t_rx_mode     rx_mode = RX_OPEN;
    logic [15:0]  last_sample = '0;

    initial begin
        foreach (coef_reg[i]) coef_reg[i] = '0;
        hist_x1 = 0; hist_x2 = 0; hist_y1 = 0; hist_y2 = 0;
    end

    // ------------------------------------------------------- predictor
    // round half up: add half an LSB, then arithmetic shift (floor)
    function automatic longint round_off(longint a, int s);
        return (a + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint a, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (a > hi) return hi;
        if (a < lo) return lo;
        return a;
    endfunction

    // one filter step: returns the output beat and advances the history
    function automatic t_filt_beat biquad_step(logic [15:0] x_bits);
        longint k0, k1, k2, k3, x, xs, acc, inner_raw, inner, wide, y_raw, y_sat;
        t_filt_beat r;
        k0 = longint'($signed(coef_reg[lpiir_pkg::REG_K0]));
        k1 = longint'($signed(coef_reg[lpiir_pkg::REG_K1]));
        k2 = longint'($signed(coef_reg[lpiir_pkg::REG_K2]));
        k3 = longint'($signed(coef_reg[lpiir_pkg::REG_K3]));
        x  = longint'($signed(x_bits));
        xs = x + 2 * hist_x1 + hist_x2;
        acc = k1 * hist_y1 + k2 * hist_y2 + k3 * (xs <<< GUARD_W);
        inner_raw = round_off(acc, lpiir_pkg::COEF_FRAC);
        inner     = clamp(inner_raw, INNER_W);
        wide      = round_off(k0 * inner, lpiir_pkg::COEF_FRAC);
        y_raw     = round_off(wide, GUARD_W);
        y_sat     = clamp(y_raw, SAMP_W);
        r.sample  = y_sat[SAMP_W-1:0];
        // any of the three saturations flags the beat
        r.clipped = (inner != inner_raw) || (y_sat != y_raw) ||
                    (clamp(wide, HIST_W) != wide);
        hist_y2 = hist_y1;
        hist_y1 = clamp(wide, HIST_W);
        hist_x2 = hist_x1;
        hist_x1 = x;
        return r;
    endfunction

    // ------------------------------------------------------- source driver
    // Bursts of random length separated by random gaps; a beat is held
    // until the filter takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                s_tdata  <= sample_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150)
                                                           : $urandom_range(0, 10);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------- sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (rdy_left == 0) begin
                rx_mode  = t_rx_mode'($urandom_range(0, 3));
                rdy_left = $urandom_range(20, 400);
            end
            rdy_left--;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default:   m_tready <= ((rdy_left % 160) < 8);   // long stalls
            endcase
        end
    end

    // ------------------------------------------------------- monitor
    // Output beats are checked before this edge's input beat is predicted.
    always @(posedge i_clk) begin : mon
        t_filt_beat want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    $error("output beat with nothing expected: filtered_out %0d",
                           $signed(m_tdata));
                    err_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_tdata !== want.sample) begin
                        $error("filtered_out: expected %0d, actual %0d",
                               $signed(want.sample), $signed(m_tdata));
                        err_count++;
                    end
                    if (m_tuser !== want.clipped) begin
                        $error("clipped: expected %0d, actual %0d", want.clipped, m_tuser);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                filtered_q.push_back(biquad_step(s_tdata));
        end
    end

    // ------------------------------------------------------- APB access
    task automatic coef_write(input logic [lpiir_pkg::REG_IW-1:0] idx,
                              input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);                // register updates on this edge
        coef_reg[idx] = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;                 // next cycle is the read setup
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== val) begin
            $error("prdata: expected %h, actual %h", val, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic coef_load(input logic [31:0] k0, k1, k2, k3);
        coef_write(lpiir_pkg::REG_K0, k0);
        coef_write(lpiir_pkg::REG_K1, k1);
        coef_write(lpiir_pkg::REG_K2, k2);
        coef_write(lpiir_pkg::REG_K3, k3);
    endtask

    // wait until every sent sample has come back, plus a short margin
    task automatic drain();
        while (sample_q.size() != 0 || s_tvalid || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------- stimulus
    function automatic logic [15:0] pick_sample();
        t_samp_kind k;
        k = t_samp_kind'($urandom_range(0, 3));
        case (k)
            SM_FULL:    last_sample = 16'($urandom_range(0, 16'hFFFF));
            SM_SMALL:   last_sample = 16'($signed($urandom_range(0, 512)) - 256);
            SM_EXTREME: last_sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default:    ;                // hold: steps and steady state
        endcase
        return last_sample;
    endfunction

    task automatic random_coefs(input t_coef_kind kind);
        longint k1q, r, k2q, k3q;
        logic [31:0] c0, c1, c2, c3;
        case (kind)
            CF_LOWPASS: begin
                // double real pole at r; unity DC gain
                k1q = longint'($urandom_range(ONE_Q24, 32715571));
                r   = k1q / 2;
                k2q = -((r * r) >>> lpiir_pkg::COEF_FRAC);
                k3q = (ONE_Q24 - k1q - k2q) / 4;
                c0 = ONE_Q24; c1 = k1q[31:0]; c2 = k2q[31:0]; c3 = k3q[31:0];
            end
            CF_WILD: begin
                c0 = $urandom; c1 = $urandom; c2 = $urandom; c3 = $urandom;
            end
            CF_RAMP: begin
                // integrator: history climbs into saturation
                k3q = longint'($urandom_range(1 << 14, 1 << 18));
                if ($urandom_range(0, 1)) k3q = -k3q;
                c0 = ONE_Q24; c1 = ONE_Q24; c2 = '0; c3 = k3q[31:0];
            end
            CF_MODERATE: begin
                c0 = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
                c1 = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
                c2 = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
                c3 = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
            end
            default: begin
                c0 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                c1 = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
                c2 = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
                c3 = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            end
        endcase
        coef_load(c0, c1, c2, c3);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: output stays at zero
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h0001);
        drain();

        // pass-through of x + 2*x1 + x2: extremes clip at the output
        coef_load(ONE_Q24, '0, '0, ONE_Q24);
        sample_q.push_back(16'h7FFF); sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h7FFF); sample_q.push_back(16'h8000);
        sample_q.push_back(16'h8000); sample_q.push_back(16'h8000);
        sample_q.push_back(16'h0000); sample_q.push_back(16'h0000);
        sample_q.push_back(16'h0000); sample_q.push_back(16'h0001);
        sample_q.push_back(16'hFFFF); sample_q.push_back(16'h0000);
        sample_q.push_back(16'h7FFF); sample_q.push_back(16'h8000);
        sample_q.push_back(16'h7FFF);
        drain();

        // largest coefficients: inner sum overflows
        coef_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h8000);
        drain();

        // most negative coefficients
        coef_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h7FFF);
        drain();

        // random runs, each with its own coefficient set
        for (int run = 0; run < RUNS; run++) begin
            random_coefs(t_coef_kind'(run % 5));
            for (int n = 0; n < ITEMS_PER_RUN; n++)
                sample_q.push_back(pick_sample());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && filtered_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
